// ===== hw/rtl/rfspe_pkg.sv =====
// ----------------------------------------------------------------------------
// rfspe_pkg: shared types and constants for the RF switch pulse encoder
// Holds the command and result transaction structs, status codes, register
// indexes and reset values used by the encoder and its checker.
// ----------------------------------------------------------------------------
package rfspe_pkg;

  // Frame geometry.
  localparam int unsigned FRAME_SYMBOLS = 48;
  localparam int unsigned SYM_IDX_W     = 6;
  localparam logic [SYM_IDX_W-1:0] LAST_SYM_IDX = SYM_IDX_W'(FRAME_SYMBOLS - 1);

  // Command limits.
  localparam logic [14:0] ID_MAX   = 15'd29999;
  localparam logic [4:0]  UNIT_MAX = 5'd19;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_ID   = 2'd1;
  localparam logic [1:0] STATUS_BAD_UNIT = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_FACTOR  = 2'd2;

  // Register reset values.
  localparam logic [11:0] SHORT_PULSE_RST = 12'd284;
  localparam logic [2:0]  LONG_FACTOR_RST = 3'd2;
  localparam logic [5:0]  GAP_FACTOR_RST  = 6'd34;

  // Command transaction.
  typedef struct packed {
    logic [14:0] device_id;
    logic [4:0]  unit_number;
    logic        turn_off;
  } cmd_t;

  // Result transaction, one per mark/space pair.
  typedef struct packed {
    logic [14:0] mark_length;
    logic [17:0] space_length;
    logic        last_symbol;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== hw/rtl/rfspe_frame_builder.sv =====
// ----------------------------------------------------------------------------
// rfspe_frame_builder: command check and frame pattern generation
// Validates a command and turns it into the 48-bit long/short symbol pattern,
// one bit per symbol, with symbol 0 in bit 0.
// ----------------------------------------------------------------------------
module rfspe_frame_builder (
  input  rfspe_pkg::cmd_t                      cmd,
  output logic [rfspe_pkg::FRAME_SYMBOLS-1:0]  pattern,
  output logic [1:0]                           status
);
  import rfspe_pkg::*;

  logic [1:0] unit_group;
  logic [2:0] unit_rem;
  logic [7:0] unit_code;

  // Range checks; the id is checked before the unit.
  always_comb begin
    priority if (cmd.device_id == 15'd0 || cmd.device_id > ID_MAX) begin
      status = STATUS_BAD_ID;
    end else if (cmd.unit_number == 5'd0 || cmd.unit_number > UNIT_MAX) begin
      status = STATUS_BAD_UNIT;
    end else begin
      status = STATUS_OK;
    end
  end

  // Split the unit into groups of five with a remainder of one to five.
  always_comb begin
    priority if (cmd.unit_number > 5'd15) begin
      unit_group = 2'd3;
      unit_rem   = 3'(cmd.unit_number - 5'd15);
    end else if (cmd.unit_number > 5'd10) begin
      unit_group = 2'd2;
      unit_rem   = 3'(cmd.unit_number - 5'd10);
    end else if (cmd.unit_number > 5'd5) begin
      unit_group = 2'd1;
      unit_rem   = 3'(cmd.unit_number - 5'd5);
    end else begin
      unit_group = 2'd0;
      unit_rem   = cmd.unit_number[2:0];
    end
  end

  assign unit_code = {2'b00, unit_group, 4'b0000} + {4'b0000, unit_rem, 1'b0}
                     - 8'd1 + {7'd0, cmd.turn_off};

  // Assemble header, id, unit code and footer symbols.
  always_comb begin
    pattern = '0;
    pattern[1] = 1'b1;
    pattern[3] = 1'b1;
    pattern[5] = 1'b1;
    pattern[7] = 1'b1;
    for (int i = 0; i < 15; i++) begin
      pattern[31-i] = cmd.device_id[i];
    end
    for (int i = 0; i < 8; i++) begin
      pattern[39-i] = unit_code[i];
    end
    pattern[47:40] = '1;
  end

endmodule

// ===== hw/rtl/rf_switch_pulse_encoder.sv =====
// ----------------------------------------------------------------------------
// rf_switch_pulse_encoder: 433 MHz switch command pulse frame encoder
// Turns one switch command into 48 mark/space results, or one error result.
// ----------------------------------------------------------------------------
// Output path: the first result of an accepted command passes the sequencer
//   register and then the result register.
// Frames: a good command emits 48 results back to back, and the next
//   command is taken in the cycle its last symbol is built; a bad command
//   gives a single result.
// The symbol sequencer emits one result per cycle while a frame is out.
// Reset: synchronous; clears the sequencer and loads the register defaults.
module rf_switch_pulse_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  rfspe_pkg::cmd_t                     cmd,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rfspe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [11:0]                         cfg_data,
  output logic                                result_valid,
  output rfspe_pkg::result_t                  result
);
  import rfspe_pkg::*;

  logic [11:0] short_pulse;
  logic [2:0]  long_factor;
  logic [5:0]  gap_factor;

  logic                     sending;
  logic [SYM_IDX_W-1:0]     sym_index;
  logic [FRAME_SYMBOLS-1:0] frame_pattern;
  logic [1:0]               frame_status;

  logic [FRAME_SYMBOLS-1:0] built_pattern;
  logic [1:0]               built_status;
  logic                     accept;
  logic                     cur_last;
  logic [14:0]              long_mark;
  logic [17:0]              gap_space;
  result_t                  result_next;

  rfspe_frame_builder u_builder (
    .cmd     (cmd),
    .pattern (built_pattern),
    .status  (built_status)
  );

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_pulse <= SHORT_PULSE_RST;
      long_factor <= LONG_FACTOR_RST;
      gap_factor  <= GAP_FACTOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SHORT_PULSE: short_pulse <= cfg_data;
        CFG_LONG_FACTOR: long_factor <= cfg_data[2:0];
        CFG_GAP_FACTOR:  gap_factor  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // The current symbol closes the frame on the last index or on an error.
  assign cur_last = (frame_status != STATUS_OK) || (sym_index == LAST_SYM_IDX);
  assign busy     = sending && !cur_last;
  assign accept   = start && !busy;

  // Durations of the current symbol.
  assign long_mark = {3'd0, short_pulse} * {12'd0, long_factor};
  assign gap_space = {6'd0, short_pulse} * {12'd0, gap_factor};

  always_comb begin
    result_next.last_symbol = cur_last;
    result_next.status      = frame_status;
    if (frame_status != STATUS_OK) begin
      result_next.mark_length  = '0;
      result_next.space_length = '0;
    end else begin
      result_next.mark_length  = frame_pattern[sym_index] ? long_mark
                                                          : {3'd0, short_pulse};
      result_next.space_length = cur_last ? gap_space : {6'd0, short_pulse};
    end
  end

  // Symbol sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      sending   <= 1'b0;
      sym_index <= '0;
    end else if (accept) begin
      sending   <= 1'b1;
      sym_index <= '0;
    end else if (sending) begin
      sending   <= !cur_last;
      sym_index <= cur_last ? '0 : sym_index + SYM_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_pattern <= built_pattern;
      frame_status  <= built_status;
    end
  end

  // Result register: one transaction per cycle while a frame is out.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= sending;
    end
  end

  always_ff @(posedge clk) begin
    if (sending) begin
      result <= result_next;
    end
  end

endmodule

// ===== hw/rtl/rfspe_checker.sv =====
// ----------------------------------------------------------------------------
// rfspe_checker: port-level checks for the RF switch pulse encoder
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module rfspe_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            result_valid,
  input rfspe_pkg::result_t              result
);
  import rfspe_pkg::*;

  // An accepted command produces a result once it has passed the sequencer and result registers.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 result_valid)
    else $error("accepted command gave no result");

  // A frame runs without gaps until its last symbol.
  a_frame_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_symbol |=> result_valid)
    else $error("frame interrupted before last symbol");

  // An error result stands alone, closes the frame and carries no durations.
  a_error_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STATUS_OK |->
      result.last_symbol && result.mark_length == '0 && result.space_length == '0)
    else $error("malformed error result");

  // While busy, the frame is still being emitted.
  a_busy_sending: assert property (@(posedge clk) disable iff (rst)
    busy |=> result_valid && result.status == STATUS_OK)
    else $error("busy without frame output");

endmodule

bind rf_switch_pulse_encoder rfspe_checker u_rfspe_checker (.*);

// ===== test/rf_switch_pulse_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rf_switch_pulse_encoder_tb: self-checking bench for the pulse frame encoder
// Feeds switch commands under several register settings and sender idling
// patterns. Every result is compared with the symbol list that the bench's
// own frame builder computes for each accepted command.
// ----------------------------------------------------------------------------
module rf_switch_pulse_encoder_tb;
  import rfspe_pkg::*;

  // The fourth register index has no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  cmd_t                 cmd = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [11:0]          cfg_data = '0;
  logic                 result_valid;
  result_t              result;

  // Commands waiting to be sent and symbols waiting to be seen.
  cmd_t    pending_cmds[$];
  result_t expected_symbols[$];
  result_t want_sym;

  // Shadow copy of the timing registers.
  logic [11:0] pulse_base = SHORT_PULSE_RST;
  logic [2:0]  long_mult  = LONG_FACTOR_RST;
  logic [5:0]  gap_mult   = GAP_FACTOR_RST;

  int unsigned sender_idle_pct = 0;
  int unsigned errors = 0;

  rf_switch_pulse_encoder u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always #2 clk = ~clk;

  // Build the symbol list of one command and queue it as expected results.
  task automatic encode_command(cmd_t c);
    logic [47:0] pattern;
    logic [7:0]  unit_code;
    logic [4:0]  unit_left;
    result_t     sym;
    pattern = '0;
    sym = '0;
    sym.last_symbol = 1'b1;
    if (c.device_id == 15'd0 || c.device_id > ID_MAX) begin
      sym.status = STATUS_BAD_ID;
      expected_symbols.push_back(sym);
      return;
    end
    if (c.unit_number == 5'd0 || c.unit_number > UNIT_MAX) begin
      sym.status = STATUS_BAD_UNIT;
      expected_symbols.push_back(sym);
      return;
    end
    // Header bits, then the id from symbol 31 downward.
    for (int i = 1; i <= 7; i += 2) pattern[i] = 1'b1;
    for (int i = 0; i < 15; i++) pattern[31-i] = c.device_id[i];
    // Unit code: 16 per group of five above five, then the odd step.
    unit_code = '0;
    unit_left = c.unit_number;
    while (unit_left > 5'd5) begin
      unit_code += 8'd16;
      unit_left -= 5'd5;
    end
    unit_code += 8'(unit_left) * 8'd2 - 8'd1 + 8'(c.turn_off);
    for (int i = 0; i < 8; i++) pattern[39-i] = unit_code[i];
    // Footer.
    pattern[47:40] = '1;
    for (int k = 0; k < FRAME_SYMBOLS; k++) begin
      sym.status       = STATUS_OK;
      sym.last_symbol  = (k == FRAME_SYMBOLS - 1);
      sym.mark_length  = pattern[k] ? 15'(32'(pulse_base) * 32'(long_mult))
                                    : 15'(pulse_base);
      sym.space_length = sym.last_symbol ? 18'(32'(pulse_base) * 32'(gap_mult))
                                         : 18'(pulse_base);
      expected_symbols.push_back(sym);
    end
  endtask

  // Command driver: predicts on each accepted transaction and holds start
  // while the encoder is busy.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) encode_command(cmd);
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          cmd   <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Result monitor: each strobed result is matched against the oldest
  // expected symbol.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_symbols.size() == 0) begin
        $error("unexpected result: mark_length %0d space_length %0d last %0d status %0d",
               result.mark_length, result.space_length, result.last_symbol,
               result.status);
        errors++;
      end else begin
        want_sym = expected_symbols.pop_front();
        check_field("mark_length", want_sym.mark_length, result.mark_length);
        check_field("space_length", want_sym.space_length, result.space_length);
        check_field("last_symbol", want_sym.last_symbol, result.last_symbol);
        check_field("status", want_sym.status, result.status);
      end
    end
  end

  function automatic cmd_t make_cmd(int unsigned id, int unsigned unit, bit off);
    cmd_t c;
    c.device_id   = 15'(id);
    c.unit_number = 5'(unit);
    c.turn_off    = off;
    return c;
  endfunction

  // Mostly well-formed commands, with some fully random ones that hit the
  // id and unit range checks.
  function automatic cmd_t random_cmd();
    if ($urandom_range(99) < 85)
      return make_cmd($urandom_range(29999, 1), $urandom_range(19, 1),
                      1'($urandom_range(1)));
    return make_cmd($urandom_range(32767), $urandom_range(31),
                    1'($urandom_range(1)));
  endfunction

  task automatic queue_random(int unsigned count);
    repeat (count) pending_cmds.push_back(random_cmd());
  endtask

  // Wait until every command is sent and every symbol has been seen.
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || start || expected_symbols.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write transaction; the shadow copy follows the handshake.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SHORT_PULSE: pulse_base = data;
      CFG_LONG_FACTOR: long_mult  = data[2:0];
      CFG_GAP_FACTOR:  gap_mult   = data[5:0];
      default: ;
    endcase
  endtask

  // Stimulus sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, no idling: range edges, unit groups and both commands.
    sender_idle_pct = 0;
    pending_cmds.push_back(make_cmd(1, 1, 0));
    pending_cmds.push_back(make_cmd(29999, 19, 1));
    pending_cmds.push_back(make_cmd(0, 5, 0));
    pending_cmds.push_back(make_cmd(30000, 5, 0));
    pending_cmds.push_back(make_cmd(32767, 31, 1));
    pending_cmds.push_back(make_cmd(0, 0, 1));
    pending_cmds.push_back(make_cmd(1, 0, 0));
    pending_cmds.push_back(make_cmd(1, 20, 1));
    pending_cmds.push_back(make_cmd(1, 31, 0));
    pending_cmds.push_back(make_cmd(21845, 5, 0));
    pending_cmds.push_back(make_cmd(10922, 6, 1));
    pending_cmds.push_back(make_cmd(16384, 10, 0));
    pending_cmds.push_back(make_cmd(12345, 11, 1));
    pending_cmds.push_back(make_cmd(100, 15, 0));
    pending_cmds.push_back(make_cmd(200, 16, 1));
    pending_cmds.push_back(make_cmd(300, 19, 0));
    pending_cmds.push_back(make_cmd(7, 1, 1));
    queue_random(50);
    wait_drained();

    // Largest durations; all data bits set so the narrow registers mask.
    write_reg(CFG_SHORT_PULSE, 12'hFFF);
    write_reg(CFG_LONG_FACTOR, 12'hFFF);
    write_reg(CFG_GAP_FACTOR, 12'hFFF);
    sender_idle_pct = 68;
    queue_random(55);
    wait_drained();

    // Smallest legal durations.
    write_reg(CFG_SHORT_PULSE, 12'd1);
    write_reg(CFG_LONG_FACTOR, 12'd1);
    write_reg(CFG_GAP_FACTOR, 12'd1);
    sender_idle_pct = 11;
    queue_random(50);
    wait_drained();

    // Zero factors, and a write to the unused index that must change nothing.
    write_reg(CFG_SHORT_PULSE, 12'($urandom_range(4095, 1)));
    write_reg(CFG_LONG_FACTOR, 12'd0);
    write_reg(CFG_GAP_FACTOR, 12'd0);
    write_reg(CFG_SPARE_IDX, 12'($urandom_range(4095)));
    sender_idle_pct = 68;
    queue_random(40);
    wait_drained();

    // Zero base pulse: every duration comes out as zero.
    write_reg(CFG_SHORT_PULSE, 12'd0);
    write_reg(CFG_LONG_FACTOR, 12'($urandom_range(4095)));
    write_reg(CFG_GAP_FACTOR, 12'($urandom_range(4095)));
    sender_idle_pct = 0;
    queue_random(20);
    wait_drained();

    // Random settings with light idling.
    write_reg(CFG_SHORT_PULSE, 12'($urandom_range(4095, 1)));
    write_reg(CFG_LONG_FACTOR, 12'($urandom_range(4095)) | 12'd1);
    write_reg(CFG_GAP_FACTOR, 12'($urandom_range(4095)) | 12'd1);
    sender_idle_pct = 11;
    queue_random(45);
    wait_drained();

    repeat (10) @(posedge clk);
    if (errors == 0 && expected_symbols.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
